FILE: hw/rtl/stpe_pkg.sv
// Shared widths, register indexes and types for the state-time power estimator.
package stpe_pkg;

  localparam int unsigned CNT_W       = 32;  // tick counter width
  localparam int unsigned CUR_W       = 16;  // per-state current weight width
  localparam int unsigned VOLT_W      = 16;
  localparam int unsigned AVG_W       = 32;
  localparam int unsigned NUM_LANES   = 5;   // cpu, lpm, deep lpm, tx, rx
  localparam int unsigned LANE_PROD_W = CNT_W + CUR_W;        // 48
  localparam int unsigned SUM_W       = LANE_PROD_W + 3;      // 51
  localparam int unsigned FACTOR_W    = 26;                   // 1000 * voltage
  localparam int unsigned SPLIT_W     = 26;                   // low part of sum
  localparam int unsigned PROD_W      = SUM_W + FACTOR_W;     // 77
  localparam int unsigned AVG_SUM_W   = AVG_W + 3;            // 35
  localparam int unsigned STEP_W      = 7;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [STEP_W-1:0] PWR_STEPS = STEP_W'(PROD_W);

  localparam logic [9:0]       VOLT_SCALE  = 10'd1000;
  // (60a + 40p) / 100 = (3a + 2p) / 5, done by folding and a reciprocal multiply
  localparam logic [CNT_W-1:0] AVG_RECIP    = 32'hCCCC_CCCD;  // ceil(2^34 / 5)
  localparam int unsigned      AVG_RECIP_SH = 34;
  localparam logic [CNT_W-1:0] AVG_WRAP_Q   = 32'd858993459;  // 2^32 = 5 * this + 1
  localparam logic [VOLT_W-1:0] VOLT_RESET = 16'd3;

  localparam logic [REG_IDX_W-1:0] REG_SUPPLY_VOLTAGE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CPU_CURRENT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LPM_CURRENT      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEEP_LPM_CURRENT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TX_CURRENT       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RX_CURRENT       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_AVERAGE  = 3'd6;

  localparam logic OP_BASELINE = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  typedef logic [LANE_PROD_W-1:0] lane_prod_t;

  typedef struct packed {
    logic busy;
    logic ovf;   // quotient did not fit in 32 bits
  } div_status_t;

endpackage

FILE: hw/rtl/stpe_lane.sv
// One lane: wrapped counter delta times its state current, registered.
module stpe_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [stpe_pkg::CNT_W-1:0]  count_i,
  input  logic [stpe_pkg::CNT_W-1:0]  prev_i,
  input  logic [stpe_pkg::CUR_W-1:0]  current_i,
  output stpe_pkg::lane_prod_t        prod_o
);
  import stpe_pkg::*;

  logic [CNT_W-1:0] delta;
  lane_prod_t       prod_d, prod_q;

  assign delta  = count_i - prev_i;
  assign prod_d = LANE_PROD_W'(delta) * LANE_PROD_W'(current_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/stpe_merge.sv
// Lane merge: sum the lane products, then scale by 1000 * voltage in two halves.
module stpe_merge (
  input  logic                         clk_i,
  input  logic                         sum_en_i,
  input  logic                         mul_en_i,
  input  stpe_pkg::lane_prod_t         lane_prod_i [stpe_pkg::NUM_LANES],
  input  logic [stpe_pkg::VOLT_W-1:0]  voltage_i,
  output logic [stpe_pkg::PROD_W-1:0]  prod_o
);
  import stpe_pkg::*;

  logic [SUM_W-1:0]             sum_d, sum_q;
  logic [FACTOR_W-1:0]          factor_q;
  logic [SPLIT_W+FACTOR_W-1:0]  pp_lo_q;
  logic [PROD_W-SPLIT_W-1:0]    pp_hi_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_d = sum_d + SUM_W'(lane_prod_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q    <= sum_d;
      factor_q <= FACTOR_W'(FACTOR_W'(voltage_i) * FACTOR_W'(VOLT_SCALE));
    end
    if (mul_en_i) begin
      pp_lo_q <= (SPLIT_W+FACTOR_W)'(sum_q[SPLIT_W-1:0]) * (SPLIT_W+FACTOR_W)'(factor_q);
      pp_hi_q <= (PROD_W-SPLIT_W)'(sum_q[SUM_W-1:SPLIT_W]) * (PROD_W-SPLIT_W)'(factor_q);
    end
  end

  assign prod_o = PROD_W'(pp_lo_q) + {pp_hi_q, {SPLIT_W{1'b0}}};

endmodule

FILE: hw/rtl/stpe_div.sv
// Serial restoring divider: one quotient bit per cycle from a left-aligned dividend.
module stpe_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [stpe_pkg::PROD_W-1:0]  dividend_i,
  input  logic [stpe_pkg::CNT_W-1:0]   divisor_i,
  input  logic [stpe_pkg::STEP_W-1:0]  steps_i,
  output logic [stpe_pkg::CNT_W-1:0]   quotient_o,
  output stpe_pkg::div_status_t        status_o
);
  import stpe_pkg::*;

  logic                busy_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [PROD_W-1:0]   dvd_q;
  logic [CNT_W-1:0]    dvs_q;
  logic [CNT_W-1:0]    rem_q;
  logic [CNT_W-1:0]    quo_q;
  logic                ovf_q;
  logic [CNT_W:0]      rem_sh;
  logic                ge;
  logic [CNT_W:0]      rem_sub;

  assign rem_sh  = {rem_q, dvd_q[PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
      rem_q <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_q <= {quo_q[CNT_W-2:0], ge};
      // a set bit leaving the top means the quotient exceeds 32 bits
      ovf_q <= ovf_q | quo_q[CNT_W-1];
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.ovf  = ovf_q;

endmodule

FILE: hw/rtl/state_time_power_estimator.sv
// Top level: state-time power estimator with moving average.
//
//  port group   dir  payload (low bit first)                        when taken
//  s_axis       in   tuser: opcode; tdata: total, cpu, lpm, deep,    tvalid & tready
//                    tx, rx ticks (32 bits each)
//  m_axis       out  tuser: power_saturated; tdata: sample_power,   tvalid & tready
//                    average_power
//  cfg          in   cfg_addr_i register index, cfg_wdata_i value   cfg_we_i
//
// A sample word passes the lanes, the merge sum and multiply, the serial divider (77
// quotient bits for the power), the average fold and the handoff add before it reaches
// the output register. A baseline word goes from idle straight to the done state.
// The result register frees the input as soon as it is loaded; a stalled output
// holds the next finished result in the done state until the word is taken.
// Reset clears control, counters snapshot, average and registers (voltage to 3).
module state_time_power_estimator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [191:0]                      s_axis_tdata,  // total, cpu, lpm, deep, tx, rx
  input  logic                              s_axis_tuser,  // opcode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [63:0]                       m_axis_tdata,  // sample_power, average_power
  output logic                              m_axis_tuser,  // power_saturated
  input  logic                              cfg_we_i,
  input  logic [stpe_pkg::REG_IDX_W-1:0]    cfg_addr_i,
  input  logic [stpe_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import stpe_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SUM    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_PSTART = 3'd3;
  localparam logic [2:0] S_PWAIT  = 3'd4;
  localparam logic [2:0] S_ASTART = 3'd5;
  localparam logic [2:0] S_AWAIT  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]         state_q, state_d;

  logic [VOLT_W-1:0]  volt_q;
  logic [CUR_W-1:0]   cur_q  [NUM_LANES];
  logic [AVG_W-1:0]   init_avg_q;

  logic [CNT_W-1:0]   prev_total_q;
  logic [CNT_W-1:0]   prev_q [NUM_LANES];
  logic [CNT_W-1:0]   dt_q;
  logic [AVG_W-1:0]   avg_q;
  logic [CNT_W-1:0]   power_q;
  logic               sat_q;

  logic               out_valid_q;
  logic [CNT_W-1:0]   out_power_q;
  logic [AVG_W-1:0]   out_avg_q;
  logic               out_sat_q;

  logic               in_fire;
  logic               out_load;
  logic [CNT_W-1:0]   in_total;
  logic [CNT_W-1:0]   in_cnt [NUM_LANES];
  logic [CNT_W-1:0]   dt_raw;

  lane_prod_t         lane_prod [NUM_LANES];
  logic [PROD_W-1:0]  scaled_sum;
  logic [AVG_SUM_W-1:0] avg_mix;

  logic [AVG_SUM_W-CNT_W-1:0] mix_hi;
  logic [CNT_W:0]       fold1;
  logic [CNT_W-1:0]     fold2;
  logic [2:0]           wrap_cnt;
  logic [CNT_W-1:0]     avg_base;
  logic [CNT_W-1:0]     avg_rem_q;
  logic [CNT_W-1:0]     avg_base_q;
  logic [2*CNT_W-1:0]   avg_recip;

  logic               div_start;
  logic [PROD_W-1:0]  div_dividend;
  logic [CNT_W-1:0]   div_divisor;
  logic [STEP_W-1:0]  div_steps;
  logic [CNT_W-1:0]   div_quo;
  div_status_t        div_stat;

  assign in_total = s_axis_tdata[CNT_W-1:0];
  assign dt_raw   = in_total - prev_total_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign in_cnt[g] = s_axis_tdata[CNT_W*(g+1) +: CNT_W];

    stpe_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (in_fire && (s_axis_tuser == OP_SAMPLE)),
      .count_i   (in_cnt[g]),
      .prev_i    (prev_q[g]),
      .current_i (cur_q[g]),
      .prod_o    (lane_prod[g])
    );
  end

  stpe_merge u_merge (
    .clk_i       (clk_i),
    .sum_en_i    (state_q == S_SUM),
    .mul_en_i    (state_q == S_MUL),
    .lane_prod_i (lane_prod),
    .voltage_i   (volt_q),
    .prod_o      (scaled_sum)
  );

  assign avg_mix = {3'b000, avg_q} + {2'b00, avg_q, 1'b0} + {2'b00, power_q, 1'b0};

  // fold the bits above 2^32 back in, since 2^32 leaves a remainder of 1 modulo 5
  assign mix_hi   = avg_mix[AVG_SUM_W-1:CNT_W];
  assign fold1    = {1'b0, avg_mix[CNT_W-1:0]} + (CNT_W+1)'(mix_hi);
  assign fold2    = fold1[CNT_W-1:0] + CNT_W'(fold1[CNT_W]);
  assign wrap_cnt = mix_hi + 3'(fold1[CNT_W]);
  assign avg_base = CNT_W'(wrap_cnt) * AVG_WRAP_Q;
  assign avg_recip = (2*CNT_W)'(avg_rem_q) * (2*CNT_W)'(AVG_RECIP);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = scaled_sum;
    div_divisor  = dt_q;
    div_steps    = PWR_STEPS;
    if (state_q == S_PSTART) begin
      div_start = 1'b1;
    end
  end

  stpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .quotient_o (div_quo),
    .status_o   (div_stat)
  );

  // control sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (s_axis_tuser == OP_SAMPLE) ? S_SUM : S_DONE;
        end
      end
      S_SUM:    state_d = S_MUL;
      S_MUL:    state_d = S_PSTART;
      S_PSTART: state_d = S_PWAIT;
      S_PWAIT: begin
        if (!div_stat.busy) begin
          state_d = S_ASTART;
        end
      end
      S_ASTART: state_d = S_AWAIT;
      S_AWAIT:  state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_q     <= VOLT_RESET;
      init_avg_q <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        cur_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SUPPLY_VOLTAGE:   volt_q     <= cfg_wdata_i[VOLT_W-1:0];
        REG_CPU_CURRENT:      cur_q[0]   <= cfg_wdata_i[CUR_W-1:0];
        REG_LPM_CURRENT:      cur_q[1]   <= cfg_wdata_i[CUR_W-1:0];
        REG_DEEP_LPM_CURRENT: cur_q[2]   <= cfg_wdata_i[CUR_W-1:0];
        REG_TX_CURRENT:       cur_q[3]   <= cfg_wdata_i[CUR_W-1:0];
        REG_RX_CURRENT:       cur_q[4]   <= cfg_wdata_i[CUR_W-1:0];
        REG_INITIAL_AVERAGE:  init_avg_q <= cfg_wdata_i[AVG_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // counter snapshot and average
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_total_q <= '0;
      avg_q        <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        prev_q[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        prev_total_q <= in_total;
        for (int i = 0; i < NUM_LANES; i++) begin
          prev_q[i] <= in_cnt[i];
        end
        if (s_axis_tuser == OP_BASELINE) begin
          avg_q <= init_avg_q;
        end
      end
      if (state_q == S_AWAIT) begin
        avg_q <= avg_base_q + CNT_W'(avg_recip[2*CNT_W-1:AVG_RECIP_SH]);
      end
    end
  end

  // interval power
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dt_q <= (dt_raw == '0) ? CNT_W'(1) : dt_raw;
      if (s_axis_tuser == OP_BASELINE) begin
        power_q <= '0;
        sat_q   <= 1'b0;
      end
    end
    if (state_q == S_PWAIT && !div_stat.busy) begin
      power_q <= div_stat.ovf ? '1 : div_quo;
      sat_q   <= div_stat.ovf;
    end
    if (state_q == S_ASTART) begin
      avg_rem_q  <= fold2;
      avg_base_q <= avg_base;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_power_q <= power_q;
      out_avg_q   <= avg_q;
      out_sat_q   <= sat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_avg_q, out_power_q};
  assign m_axis_tuser  = out_sat_q;

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PSTART) |-> !div_stat.busy)
    else $error("divider started while busy");

  a_baseline_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tuser == OP_BASELINE) |=> (state_q == S_DONE && power_q == '0 && !sat_q))
    else $error("baseline did not yield zero power");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PWAIT && !div_stat.busy && div_stat.ovf) |=> (sat_q && power_q == '1))
    else $error("saturated power not clamped");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !m_axis_tready) |=> (state_q == S_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule
